FILE: rtl/core/status_led_pattern_driver_assert.svh
// Assertion macros for the status LED pattern driver.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef STATUS_LED_PATTERN_DRIVER_ASSERT_SVH
`define STATUS_LED_PATTERN_DRIVER_ASSERT_SVH

// Check a same-cycle implication outside reset.
`define SLPD_CHECK_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("%m: check failed");

// Check an implication in the following cycle, outside reset.
`define SLPD_CHECK_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("%m: check failed");

`endif

FILE: rtl/core/slpd_pkg.sv
// Shared types and constants for the status LED pattern driver.
// No dependencies; used by slpd_cfg, slpd_core and the top level.
`default_nettype none

package slpd_pkg;

    localparam int TIMER_BITS = 16;
    localparam int DUR_W      = 16;
    localparam int CMP_W      = (TIMER_BITS > DUR_W) ? TIMER_BITS : DUR_W;

    localparam int CFG_IDX_W  = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_SHORT_STEP = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAUSE_STEP = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PULSE      = 2'd2;

    localparam logic [DUR_W-1:0] SHORT_STEP_RST = 16'd250;
    localparam logic [DUR_W-1:0] PAUSE_STEP_RST = 16'd1000;
    localparam logic [DUR_W-1:0] PULSE_RST      = 16'd80;

    localparam logic [1:0] CMD_TICK   = 2'd0;
    localparam logic [1:0] CMD_STATUS = 2'd1;
    localparam logic [1:0] CMD_PULSE  = 2'd2;

    localparam logic [1:0] MODE_OFF      = 2'd0;
    localparam logic [1:0] MODE_CHECKING = 2'd1;
    localparam logic [1:0] MODE_WAIT     = 2'd2;
    localparam logic [1:0] MODE_JUMP     = 2'd3;

    localparam logic [2:0] STEP_FIRST = 3'd0;
    localparam logic [2:0] STEP_RESUME = 3'd1;
    localparam logic [2:0] PAUSE_STEP = 3'd6;

    typedef struct packed {
        logic [DUR_W-1:0] short_step_ms;
        logic [DUR_W-1:0] pause_step_ms;
        logic [DUR_W-1:0] pulse_ms;
    } cfg_t;

endpackage

`default_nettype wire

FILE: rtl/core/slpd_cfg.sv
// Configuration register file for the status LED pattern driver.
// Depends on slpd_pkg for the register indexes, reset values and cfg_t.
`default_nettype none

module slpd_cfg (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [slpd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [slpd_pkg::DUR_W-1:0]     cfg_data,
    output slpd_pkg::cfg_t                     cfg
);

    slpd_pkg::cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.short_step_ms <= slpd_pkg::SHORT_STEP_RST;
            cfg_reg.pause_step_ms <= slpd_pkg::PAUSE_STEP_RST;
            cfg_reg.pulse_ms      <= slpd_pkg::PULSE_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                slpd_pkg::CFG_SHORT_STEP: cfg_reg.short_step_ms <= cfg_data;
                slpd_pkg::CFG_PAUSE_STEP: cfg_reg.pause_step_ms <= cfg_data;
                slpd_pkg::CFG_PULSE:      cfg_reg.pulse_ms      <= cfg_data;
                default: ;
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/slpd_core.sv
// LED pattern state and combinational event update for the status LED driver.
// Depends on slpd_pkg and status_led_pattern_driver_assert.svh.
`default_nettype none
`include "status_led_pattern_driver_assert.svh"

module slpd_core (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire slpd_pkg::cfg_t cfg,
    input  wire logic           step_en,
    input  wire logic [1:0]     cmd,
    input  wire logic [1:0]     status_value,
    output logic                led_next
);

    localparam int TB = slpd_pkg::TIMER_BITS;
    localparam int CW = slpd_pkg::CMP_W;

    logic [1:0]    mode_reg, mode_next;
    logic          pulse_active_reg, pulse_active_next;
    logic [TB-1:0] pulse_elapsed_reg, pulse_elapsed_next;
    logic [TB-1:0] toggle_elapsed_reg, toggle_elapsed_next;
    logic [2:0]    wait_step_reg, wait_step_next;
    logic          led_lit_reg, led_lit_next;

    logic          run_task;
    logic          pulse_hold;
    logic [slpd_pkg::DUR_W-1:0] step_len;

    always_comb begin
        mode_next           = mode_reg;
        pulse_active_next   = pulse_active_reg;
        pulse_elapsed_next  = pulse_elapsed_reg;
        toggle_elapsed_next = toggle_elapsed_reg;
        wait_step_next      = wait_step_reg;
        led_lit_next        = led_lit_reg;
        run_task            = 1'b1;
        pulse_hold          = 1'b0;
        step_len            = cfg.short_step_ms;

        case (cmd)
            slpd_pkg::CMD_TICK: begin
                if (pulse_elapsed_reg != {TB{1'b1}})
                    pulse_elapsed_next = pulse_elapsed_reg + 1'b1;
                if (toggle_elapsed_reg != {TB{1'b1}})
                    toggle_elapsed_next = toggle_elapsed_reg + 1'b1;
            end
            slpd_pkg::CMD_STATUS: begin
                mode_next           = status_value;
                toggle_elapsed_next = '0;
                pulse_active_next   = 1'b0;
                wait_step_next      = slpd_pkg::STEP_FIRST;
                led_lit_next        = (status_value == slpd_pkg::MODE_CHECKING) ||
                                      (status_value == slpd_pkg::MODE_WAIT);
            end
            slpd_pkg::CMD_PULSE: begin
                pulse_elapsed_next = '0;
                pulse_active_next  = 1'b1;
                led_lit_next       = 1'b1;
            end
            default: begin
                run_task = 1'b0;
            end
        endcase

        if (run_task) begin
            if (pulse_active_next) begin
                if (CW'(pulse_elapsed_next) < CW'(cfg.pulse_ms)) begin
                    led_lit_next = 1'b1;
                    pulse_hold   = 1'b1;
                end else begin
                    pulse_active_next   = 1'b0;
                    led_lit_next        = 1'b0;
                    toggle_elapsed_next = '0;
                    wait_step_next      = slpd_pkg::STEP_RESUME;
                end
            end
            if (!pulse_hold) begin
                if (mode_next == slpd_pkg::MODE_WAIT) begin
                    step_len = (wait_step_next == slpd_pkg::PAUSE_STEP) ?
                               cfg.pause_step_ms : cfg.short_step_ms;
                    if (CW'(toggle_elapsed_next) >= CW'(step_len)) begin
                        toggle_elapsed_next = '0;
                        wait_step_next = (wait_step_next >= slpd_pkg::PAUSE_STEP) ?
                                         slpd_pkg::STEP_FIRST : wait_step_next + 3'd1;
                        led_lit_next = (wait_step_next < slpd_pkg::PAUSE_STEP) &&
                                       !wait_step_next[0];
                    end
                end else if (mode_next == slpd_pkg::MODE_CHECKING) begin
                    led_lit_next = 1'b1;
                end else begin
                    led_lit_next = 1'b0;
                end
            end
        end
    end

    assign led_next = led_lit_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg           <= slpd_pkg::MODE_OFF;
            pulse_active_reg   <= 1'b0;
            pulse_elapsed_reg  <= '0;
            toggle_elapsed_reg <= '0;
            wait_step_reg      <= slpd_pkg::STEP_FIRST;
            led_lit_reg        <= 1'b0;
        end else if (step_en) begin
            mode_reg           <= mode_next;
            pulse_active_reg   <= pulse_active_next;
            pulse_elapsed_reg  <= pulse_elapsed_next;
            toggle_elapsed_reg <= toggle_elapsed_next;
            wait_step_reg      <= wait_step_next;
            led_lit_reg        <= led_lit_next;
        end
    end

    `SLPD_CHECK_IMPL(a_step_in_range, aclk, aresetn, 1'b1,
        wait_step_reg <= slpd_pkg::PAUSE_STEP)
    `SLPD_CHECK_IMPL(a_pulse_lit, aclk, aresetn, pulse_active_reg, led_lit_reg)
    `SLPD_CHECK_IMPL(a_dark_modes, aclk, aresetn,
        !pulse_active_reg && (mode_reg == slpd_pkg::MODE_OFF ||
        mode_reg == slpd_pkg::MODE_JUMP), !led_lit_reg)
    `SLPD_CHECK_IMPL(a_wait_pattern, aclk, aresetn,
        !pulse_active_reg && mode_reg == slpd_pkg::MODE_WAIT,
        led_lit_reg == ((wait_step_reg < slpd_pkg::PAUSE_STEP) && !wait_step_reg[0]))

endmodule

`default_nettype wire

FILE: rtl/core/status_led_pattern_driver.sv
// Status LED pattern driver: stream handshake, result register and config port.
// Depends on slpd_pkg, slpd_cfg, slpd_core and status_led_pattern_driver_assert.svh.
//
// Usage:
//   s_ channel carries one event per transfer: s_tuser holds the command
//   (tick, set status, activity pulse), s_tdata holds the new status.
//   m_ channel returns one transfer per event with the LED state after it.
//   cfg_ channel writes short_step_ms, pause_step_ms and pulse_ms by index;
//   write it only while no event is in flight. cfg_ready is always high.
//   The result is registered and appears on m_ in the cycle after the input transfer.
//   Throughput: one event per cycle unless m_ stalls; the state update is a single
//   combinational step between the state registers and the result register.
//   A stalled receiver holds the result; s_tready stays high as long as the
//   result register is empty or is being drained in the same cycle.
//   Reset (aresetn low, synchronous) sets off mode, dark LED, cleared
//   counters, default durations and an empty result register.
`default_nettype none
`include "status_led_pattern_driver_assert.svh"

module status_led_pattern_driver (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [7:0]                     s_tdata,   // [1:0] status_value
    input  wire logic [1:0]                     s_tuser,   // [1:0] cmd
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [7:0]                          m_tdata,   // [0] led_on
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [slpd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [slpd_pkg::DUR_W-1:0]     cfg_data
);

    slpd_pkg::cfg_t cfg;
    logic           accept;
    logic           led_next;
    logic           out_valid_reg;
    logic           out_led_reg;

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_led_reg};

    slpd_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    slpd_core u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg),
        .step_en      (accept),
        .cmd          (s_tuser),
        .status_value (s_tdata[1:0]),
        .led_next     (led_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (accept) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            out_led_reg <= led_next;
        end
    end

    `SLPD_CHECK_NEXT(a_result_follows, aclk, aresetn, accept,
        m_tvalid && (m_tdata[0] == $past(led_next)))
    `SLPD_CHECK_NEXT(a_result_held, aclk, aresetn, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata))
    `SLPD_CHECK_IMPL(a_ready_when_empty, aclk, aresetn, !m_tvalid, s_tready)

endmodule

`default_nettype wire

FILE: tb/sv/status_led_pattern_driver_checker.sv
// Scoreboard for the status LED pattern driver: watches the event, result and config
// channels, predicts the LED state after each event and compares it. Depends on slpd_pkg.
`timescale 1ns / 1ps

module status_led_pattern_driver_checker
    import slpd_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [7:0]           s_tdata,   // [1:0] status_value
    input  logic [1:0]           s_tuser,   // [1:0] cmd
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [7:0]           m_tdata,   // [0] led_on
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DUR_W-1:0]     cfg_data,
    output int                   failures,
    output int                   outstanding
);

    logic [DUR_W-1:0]      short_len;
    logic [DUR_W-1:0]      pause_len;
    logic [DUR_W-1:0]      pulse_len;
    logic [1:0]            led_mode;
    bit                    pulse_on;
    logic [TIMER_BITS-1:0] pulse_age;
    logic [TIMER_BITS-1:0] step_age;
    logic [2:0]            step_idx;
    bit                    lit;
    bit                    led_expected[$];

    task automatic refresh_led();
        logic [DUR_W-1:0] len;
        if (pulse_on) begin
            if (pulse_age < pulse_len) begin
                lit = 1'b1;
                return;
            end
            pulse_on = 1'b0;
            lit      = 1'b0;
            step_age = '0;
            step_idx = STEP_RESUME;
        end
        if (led_mode == MODE_WAIT) begin
            len = (step_idx == PAUSE_STEP) ? pause_len : short_len;
            if (step_age >= len) begin
                step_age = '0;
                step_idx = (step_idx >= PAUSE_STEP) ? STEP_FIRST : step_idx + 3'd1;
                lit      = (step_idx < PAUSE_STEP) && !step_idx[0];
            end
        end else if (led_mode == MODE_CHECKING) begin
            lit = 1'b1;
        end else begin
            lit = 1'b0;
        end
    endtask

    task automatic apply_event(input logic [1:0] cmd, input logic [1:0] status);
        case (cmd)
            CMD_TICK: begin
                if (pulse_age != '1) pulse_age = pulse_age + 1'b1;
                if (step_age != '1) step_age = step_age + 1'b1;
                refresh_led();
            end
            CMD_STATUS: begin
                led_mode = status;
                step_age = '0;
                pulse_on = 1'b0;
                step_idx = STEP_FIRST;
                lit      = (status == MODE_CHECKING) || (status == MODE_WAIT);
                refresh_led();
            end
            CMD_PULSE: begin
                pulse_age = '0;
                pulse_on  = 1'b1;
                lit       = 1'b1;
                refresh_led();
            end
            default: ;
        endcase
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            short_len = SHORT_STEP_RST;
            pause_len = PAUSE_STEP_RST;
            pulse_len = PULSE_RST;
            led_mode  = MODE_OFF;
            pulse_on  = 1'b0;
            pulse_age = '0;
            step_age  = '0;
            step_idx  = STEP_FIRST;
            lit       = 1'b0;
            led_expected.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_SHORT_STEP: short_len = cfg_data;
                    CFG_PAUSE_STEP: pause_len = cfg_data;
                    CFG_PULSE:      pulse_len = cfg_data;
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                if (led_expected.size() == 0) begin
                    $error("led_on: expected no transfer, got %0d", m_tdata[0]);
                    failures++;
                end else if (m_tdata[0] !== led_expected[0]) begin
                    $error("led_on: expected %0d, got %0d", led_expected[0], m_tdata[0]);
                    failures++;
                    void'(led_expected.pop_front());
                end else begin
                    void'(led_expected.pop_front());
                end
            end
            if (s_tvalid && s_tready) begin
                apply_event(s_tuser, s_tdata[1:0]);
                led_expected.push_back(lit);
            end
        end
        outstanding <= led_expected.size();
    end

endmodule

FILE: tb/sv/status_led_pattern_driver_tb.sv
// Top of the status LED pattern driver testbench: clock, reset, event and config stimulus
// under several idle/stall mixes, and the verdict. Depends on slpd_pkg and the checker.
`timescale 1ns / 1ps

module status_led_pattern_driver_tb;
    import slpd_pkg::*;

    localparam logic [1:0]           CMD_UNUSED = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int                   PHASE_EVENTS = 310;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [7:0]           s_tdata;   // [1:0] status_value
    logic [1:0]           s_tuser;   // [1:0] cmd
    logic                 m_tvalid;
    logic                 m_tready;
    logic [7:0]           m_tdata;   // [0] led_on
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [DUR_W-1:0]     cfg_data;
    int                   failures;
    int                   outstanding;
    int                   send_idle_pct;
    int                   stall_pct;
    int                   hold_left;

    status_led_pattern_driver DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    status_led_pattern_driver_checker led_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .failures    (failures),
        .outstanding (outstanding)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #10_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    task automatic send_event(input logic [1:0] cmd, input logic [1:0] status);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            s_tuser  <= 2'($urandom);
            s_tdata  <= {6'd0, 2'($urandom)};
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {6'd0, status};
        do @(posedge aclk); while (!s_tready);
    endtask

    // drop valid and hold until every result has been taken
    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
        repeat (2) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DUR_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic load_timing(input logic [DUR_W-1:0] short_ms, input logic [DUR_W-1:0] pause_ms,
                               input logic [DUR_W-1:0] pulse_len_ms);
        drain_results();
        write_reg(CFG_SHORT_STEP, short_ms);
        write_reg(CFG_PAUSE_STEP, pause_ms);
        write_reg(CFG_PULSE, pulse_len_ms);
    endtask

    task automatic random_event();
        int pick;
        pick = $urandom_range(99);
        if (pick < 70)
            send_event(CMD_TICK, 2'($urandom));
        else if (pick < 80)
            send_event(CMD_PULSE, 2'($urandom));
        else if (pick < 94)
            send_event(CMD_STATUS, ($urandom_range(9) < 5) ? MODE_WAIT : 2'($urandom));
        else
            send_event(CMD_UNUSED, 2'($urandom));
    endtask

    initial begin
        int hi;
        aresetn       = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = CMD_TICK;
        cfg_valid     = 1'b0;
        cfg_index     = CFG_SHORT_STEP;
        cfg_data      = '0;
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_left     = 0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_event(CMD_UNUSED, 2'b11);
        send_event(CMD_TICK, 2'b11);
        send_event(CMD_STATUS, MODE_CHECKING);
        send_event(CMD_PULSE, 2'b10);
        send_event(CMD_TICK, 2'b01);
        send_event(CMD_STATUS, MODE_JUMP);
        send_event(CMD_STATUS, MODE_WAIT);
        send_event(CMD_STATUS, MODE_OFF);
        send_event(CMD_UNUSED, 2'b00);

        load_timing('0, '0, '0);
        write_reg(CFG_UNUSED, 16'($urandom));
        send_event(CMD_STATUS, MODE_WAIT);
        repeat (3) send_event(CMD_TICK, 2'b00);
        send_event(CMD_PULSE, 2'b01);
        send_event(CMD_PULSE, 2'b00);
        send_event(CMD_TICK, 2'b10);
        send_event(CMD_STATUS, MODE_CHECKING);
        send_event(CMD_PULSE, 2'b11);
        send_event(CMD_STATUS, MODE_JUMP);
        send_event(CMD_PULSE, 2'b00);
        send_event(CMD_TICK, 2'b00);

        // hold a long pause and pulse that do not expire
        load_timing(16'd1, 16'hFFFF, 16'hFFFF);
        send_event(CMD_STATUS, MODE_WAIT);
        send_event(CMD_PULSE, 2'b00);
        repeat (40) send_event(CMD_TICK, 2'($urandom));

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 71; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 71; end
                default: begin send_idle_pct = 20; stall_pct = 20; end
            endcase
            hi = (ph == 3) ? 40 : 6;
            load_timing(16'($urandom_range(0, hi)), 16'($urandom_range(0, hi)),
                        16'($urandom_range(0, hi)));
            send_event(CMD_STATUS, MODE_WAIT);
            for (int n = 0; n < PHASE_EVENTS; n++) begin
                if (ph == 0 && n == 100)
                    hold_left = 250;
                if (n == PHASE_EVENTS / 2)
                    drain_results();
                random_event();
            end
        end

        drain_results();
        if (failures == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
